[hw/rtl/assert_macros.svh]
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SMT_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is active.
`define SMT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("next-cycle check failed");

`endif

[hw/rtl/smt_pkg.sv]
// Shared widths, register indexes and arithmetic helpers for the triangulation block.
package smt_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int RAY_W     = 24;
	localparam int RAY_FRAC  = 20;
	localparam int PROD_W    = 49;
	localparam int DOT_W     = 49;
	localparam int BL_W      = 56;
	localparam int NUM_W     = 128;
	localparam int DEN_W     = 100;
	localparam int QB        = 41;
	localparam int QUO_W     = QB + 1;
	localparam int DIV_LANES = 3;
	localparam int MUL_CHUNK = 32;
	localparam int M_LAT     = 5;
	localparam int D_LAT     = QB + 4;

	localparam logic [30:0]        BASE_RST = 31'd7864;
	localparam logic signed [31:0] OFF_RST  = 32'sd7864;

	localparam longint RAY_HI = (64'sd1 <<< (RAY_W - 1)) - 64'sd1;
	localparam longint RAY_LO = -(64'sd1 <<< (RAY_W - 1));
	localparam logic signed [DOT_W-1:0] DOT_ONE = DOT_W'(64'sd1 <<< (2 * RAY_FRAC));

	typedef enum logic [CFG_IDX_W-1:0] {
		IDX_INV_FX   = 3'd0,
		IDX_INV_FY   = 3'd1,
		IDX_CENTRE_X = 3'd2,
		IDX_CENTRE_Y = 3'd3,
		IDX_BASELINE = 3'd4,
		IDX_OFFSET   = 3'd5
	} cfg_idx_t;

	// Round a Q.28 ray component to Q.20 (floor after half add), then clamp.
	function automatic logic signed [RAY_W-1:0] ray_round(input logic signed [PROD_W-1:0] prod,
			input logic signed [31:0] cterm);
		logic signed [50:0] sum;
		logic signed [42:0] fl;
		sum = 51'(prod) + (51'(cterm) <<< 4) + 51'sd128;
		fl  = 43'(sum >>> 8);
		if (fl > 43'(RAY_HI))
			return RAY_W'(RAY_HI);
		else if (fl < 43'(RAY_LO))
			return RAY_W'(RAY_LO);
		else
			return fl[RAY_W-1:0];
	endfunction

	// Clamp to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
		if (v > 43'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -43'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

[hw/rtl/smt_dly.sv]
// Enabled delay line for payload that rides alongside the arithmetic stages.
module smt_dly #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] tap_q [DEPTH];

	// Shift one tap per advancing cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < DEPTH; i++)
				tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[DEPTH-1];
endmodule

[hw/rtl/smt_mul.sv]
// Pipelined signed multiplier built from 32x32 partial products.
module smt_mul #(
	parameter int WA = 32,
	parameter int WB = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    v_in,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic                    v_out,
	output logic signed [WA+WB-1:0] p
);
	import smt_pkg::*;

	localparam int CH = MUL_CHUNK;
	localparam int NA = (WA + CH - 1) / CH;
	localparam int NB = (WB + CH - 1) / CH;
	localparam int RW = CH * (NA + 1);
	localparam int PW = CH * (NA + NB);

	logic [WA-1:0]    a_mag;
	logic [WB-1:0]    b_mag;
	logic [CH*NA-1:0] am_s1;
	logic [CH*NB-1:0] bm_s1;
	logic             neg_s1, neg_s2, neg_s3, neg_s4;
	logic [2*CH-1:0]  pp_s2 [NA][NB];
	logic [RW-1:0]    row_d [NB];
	logic [RW-1:0]    row_s3 [NB];
	logic [PW-1:0]    mag_d;
	logic [PW-1:0]    mag_s4;
	logic             v_s1, v_s2, v_s3, v_s4;

	assign a_mag = a[WA-1] ? WA'(~a + 1'b1) : WA'(a);
	assign b_mag = b[WB-1] ? WB'(~b + 1'b1) : WB'(b);

	// Rows: even and odd partial products do not overlap, so each row is one add.
	always_comb begin
		logic [RW-1:0] ev, od;
		for (int j = 0; j < NB; j++) begin
			ev = '0;
			od = '0;
			for (int i = 0; i < NA; i++) begin
				if (i % 2 == 0)
					ev = ev | (RW'(pp_s2[i][j]) << (CH * i));
				else
					od = od | (RW'(pp_s2[i][j]) << (CH * i));
			end
			row_d[j] = ev + od;
		end
	end

	// Combine the rows (one or two of them).
	always_comb begin
		mag_d = '0;
		for (int j = 0; j < NB; j++)
			mag_d = mag_d + (PW'(row_s3[j]) << (CH * j));
	end

	// Advance the data stages.
	always_ff @(posedge clk) begin
		if (en) begin
			am_s1  <= (CH*NA)'(a_mag);
			bm_s1  <= (CH*NB)'(b_mag);
			neg_s1 <= a[WA-1] ^ b[WB-1];
			for (int i = 0; i < NA; i++)
				for (int j = 0; j < NB; j++)
					pp_s2[i][j] <= am_s1[CH*i +: CH] * bm_s1[CH*j +: CH];
			neg_s2 <= neg_s1;
			row_s3 <= row_d;
			neg_s3 <= neg_s2;
			mag_s4 <= mag_d;
			neg_s4 <= neg_s3;
			p      <= neg_s4 ? -$signed((WA+WB)'(mag_s4)) : $signed((WA+WB)'(mag_s4));
		end
	end

	// Advance the valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_out <= 1'b0;
		end else if (en) begin
			v_s1  <= v_in;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_out <= v_s4;
		end
	end
endmodule

[hw/rtl/smt_div.sv]
// Pipelined restoring divider, one quotient bit per stage, three lanes on one divisor.
module smt_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              v_in,
	input  logic signed [smt_pkg::NUM_W-1:0]  num [smt_pkg::DIV_LANES],
	input  logic signed [smt_pkg::DEN_W-1:0]  den,
	output logic                              v_out,
	output logic signed [smt_pkg::QUO_W-1:0]  quo [smt_pkg::DIV_LANES]
);
	import smt_pkg::*;

	localparam int CW = DEN_W + QB + 1;
	localparam logic [QB:0] CAP = (QB+1)'(1) << (QB - 1);

	logic [DEN_W-1:0] ud_s1;
	logic [NUM_W-1:0] un_s1 [DIV_LANES];
	logic             neg_s1 [DIV_LANES];
	logic             v_s1;

	logic [NUM_W-1:0] it_rem_s [QB+1][DIV_LANES];
	logic [QB-1:0]    it_quo_s [QB+1][DIV_LANES];
	logic             it_ovf_s [QB+1][DIV_LANES];
	logic             it_neg_s [QB+1][DIV_LANES];
	logic [DEN_W-1:0] it_ud_s  [QB+1];
	logic             it_v_s   [QB+1];

	logic [QB-1:0]    quo_r [DIV_LANES];
	logic             rnd_r [DIV_LANES];
	logic             ovf_r [DIV_LANES];
	logic             neg_r [DIV_LANES];
	logic             v_r;

	// Take magnitudes and the result sign.
	always_ff @(posedge clk) begin
		if (en) begin
			ud_s1 <= den[DEN_W-1] ? DEN_W'(~den + 1'b1) : DEN_W'(den);
			for (int l = 0; l < DIV_LANES; l++) begin
				un_s1[l]  <= num[l][NUM_W-1] ? NUM_W'(~num[l] + 1'b1) : NUM_W'(num[l]);
				neg_s1[l] <= num[l][NUM_W-1] ^ den[DEN_W-1];
			end
		end
	end

	// Flag quotients too large for the bit count; they clamp later.
	always_ff @(posedge clk) begin
		if (en) begin
			it_ud_s[0] <= ud_s1;
			for (int l = 0; l < DIV_LANES; l++) begin
				it_rem_s[0][l] <= un_s1[l];
				it_quo_s[0][l] <= '0;
				it_neg_s[0][l] <= neg_s1[l];
				it_ovf_s[0][l] <= (CW+1)'(un_s1[l]) >= ((CW+1)'(ud_s1) << QB);
			end
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar k = 0; k < QB; k++) begin : g_iter
		localparam int BIT = QB - 1 - k;
		logic [CW-1:0] trial;
		logic          fit [DIV_LANES];

		assign trial = CW'(it_ud_s[k]) << BIT;

		always_comb begin
			for (int l = 0; l < DIV_LANES; l++)
				fit[l] = CW'(it_rem_s[k][l]) >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				it_ud_s[k+1] <= it_ud_s[k];
				for (int l = 0; l < DIV_LANES; l++) begin
					it_rem_s[k+1][l] <= fit[l] ? NUM_W'(CW'(it_rem_s[k][l]) - trial)
						: it_rem_s[k][l];
					it_quo_s[k+1][l] <= it_quo_s[k][l] | (fit[l] ? (QB'(1) << BIT) : '0);
					it_ovf_s[k+1][l] <= it_ovf_s[k][l];
					it_neg_s[k+1][l] <= it_neg_s[k][l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				it_v_s[k+1] <= 1'b0;
			else if (en)
				it_v_s[k+1] <= it_v_s[k];
		end
	end

	// Round half away from zero: bump when twice the remainder reaches the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < DIV_LANES; l++) begin
				quo_r[l] <= it_quo_s[QB][l];
				rnd_r[l] <= {it_rem_s[QB][l], 1'b0} >= (NUM_W+1)'(it_ud_s[QB]);
				ovf_r[l] <= it_ovf_s[QB][l];
				neg_r[l] <= it_neg_s[QB][l];
			end
		end
	end

	// Clamp the magnitude and apply the sign.
	always_ff @(posedge clk) begin
		logic [QB:0] qr;
		logic [QB:0] mag;
		if (en) begin
			for (int l = 0; l < DIV_LANES; l++) begin
				qr     = (QB+1)'(quo_r[l]) + (QB+1)'(rnd_r[l]);
				mag    = (ovf_r[l] || qr > CAP) ? CAP : qr;
				quo[l] <= neg_r[l] ? -$signed(mag) : $signed(mag);
			end
		end
	end

	// Advance the valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			it_v_s[0] <= 1'b0;
			v_r       <= 1'b0;
			v_out     <= 1'b0;
		end else if (en) begin
			v_s1      <= v_in;
			it_v_s[0] <= v_s1;
			v_r       <= it_v_s[QB];
			v_out     <= v_r;
		end
	end
endmodule

[hw/rtl/stereo_midpoint_triangulation.sv]
// Top level: stereo midpoint triangulation pipeline with its register file.
//
//  channel   signals                                    direction   handshake
//  pair      left_px left_py right_px right_py          in          pair_valid / pair_stall
//  point     point_x point_y point_z rays_parallel      out         point_valid / point_stall
//  cfg       cfg_index cfg_data                         in          cfg_valid / cfg_ready
//
// One keypoint pair is taken every cycle while pair_stall is low; a result passes through
// 4 front stages, two multiplier groups of 5 stages each plus 3 add stages, a
// 45-stage divider (one quotient bit per stage) shared by the three coordinates,
// and the output register.
// Reset returns the registers to their defaults and empties the pipeline; no sweep.
// While the output holds an untaken result under stall, every stage holds and
// pair_stall is raised.
module stereo_midpoint_triangulation (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pair_valid,
	output logic                              pair_stall,
	input  logic [15:0]                       left_px,
	input  logic [15:0]                       left_py,
	input  logic [15:0]                       right_px,
	input  logic [15:0]                       right_py,
	output logic                              point_valid,
	input  logic                              point_stall,
	output logic signed [31:0]                point_x,
	output logic signed [31:0]                point_y,
	output logic signed [31:0]                point_z,
	output logic                              rays_parallel,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [smt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data
);
	import smt_pkg::*;

	localparam int SQ_W   = 2 * RAY_W;
	localparam int MM_W   = 2 * DOT_W;
	localparam int MB_W   = DOT_W + BL_W;
	localparam int DET_W  = MM_W + 1;
	localparam int NT_W   = MB_W + 1;
	localparam int NR_W   = NT_W + RAY_W;
	localparam int DB_W   = DET_W + 32;
	localparam int SUM_W  = NT_W + 1;
	localparam int ACC_W  = DB_W + 1;
	localparam int RAY_DLY = M_LAT + 3;
	localparam int AUX_DLY = M_LAT + 1;
	localparam int AUX_W   = 1 + DEN_W + SUM_W;

	logic signed [31:0] ifx_q, ify_q, cx_q, cy_q, off_q;
	logic [30:0]        base_q;
	logic signed [31:0] base_s;
	logic               en;

	logic signed [PROD_W-1:0] prod_s1 [4];
	logic signed [RAY_W-1:0]  ray_s2 [4];
	logic signed [SQ_W-1:0]   sq_s3 [4];
	logic signed [SQ_W-1:0]   lr_s3 [2];
	logic signed [BL_W-1:0]   bl_s3 [2];
	logic signed [DOT_W-1:0]  a_s4, c_s4, m_s4;
	logic signed [BL_W-1:0]   b0_s4, b1_s4;
	logic                     v_s1, v_s2, v_s3, v_s4;

	logic signed [MM_W-1:0] mm_p, ac_p;
	logic signed [MB_W-1:0] mb1_p, cb0_p, ab1_p, mb0_p;
	logic                   mm_v;

	logic [4*RAY_W-1:0]      ray_pack, ray_dly;
	logic signed [RAY_W-1:0] lx_d, ly_d, rx_d, ry_d;
	logic signed [DET_W-1:0] det_s10;
	logic signed [NT_W-1:0]  nt_s10, ns_s10;
	logic                    v_s10;

	logic signed [NR_W-1:0]  ntlx_p, nsrx_p, ntly_p, nsry_p;
	logic signed [DB_W-1:0]  detb_p;
	logic                    ntlx_v;

	logic signed [SUM_W-1:0] sum_s11;
	logic signed [DEN_W-1:0] den_s11;
	logic                    zero_s11;
	logic [AUX_W-1:0]        aux_dly;
	logic signed [SUM_W-1:0] sum_d;
	logic signed [DEN_W-1:0] den_d;
	logic                    zero_d;

	logic signed [ACC_W-1:0] sxy_s16, ny_s16;
	logic signed [DB_W-1:0]  detb_s16;
	logic                    v_s16;
	logic signed [NUM_W-1:0] nx_s17, ny_s17;
	logic                    v_s17;

	logic signed [NUM_W-1:0] num [DIV_LANES];
	logic signed [QUO_W-1:0] quo [DIV_LANES];
	logic                    quo_v;
	logic                    zero_q;

	assign en         = !point_valid || !point_stall;
	assign pair_stall = !en;
	assign cfg_ready  = 1'b1;
	assign base_s     = $signed({1'b0, base_q});

	// Write a configuration register; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ifx_q  <= '0;
			ify_q  <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
			base_q <= BASE_RST;
			off_q  <= OFF_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				IDX_INV_FX:   ifx_q  <= $signed(cfg_data);
				IDX_INV_FY:   ify_q  <= $signed(cfg_data);
				IDX_CENTRE_X: cx_q   <= $signed(cfg_data);
				IDX_CENTRE_Y: cy_q   <= $signed(cfg_data);
				IDX_BASELINE: base_q <= cfg_data[30:0];
				IDX_OFFSET:   off_q  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Front end: pixel scale, ray rounding, ray products, dot products.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= $signed({1'b0, left_px}) * ifx_q;
			prod_s1[1] <= $signed({1'b0, left_py}) * ify_q;
			prod_s1[2] <= $signed({1'b0, right_px}) * ifx_q;
			prod_s1[3] <= $signed({1'b0, right_py}) * ify_q;

			ray_s2[0] <= ray_round(prod_s1[0], cx_q);
			ray_s2[1] <= ray_round(prod_s1[1], cy_q);
			ray_s2[2] <= ray_round(prod_s1[2], cx_q);
			ray_s2[3] <= ray_round(prod_s1[3], cy_q);

			for (int j = 0; j < 4; j++)
				sq_s3[j] <= ray_s2[j] * ray_s2[j];
			lr_s3[0] <= ray_s2[0] * ray_s2[2];
			lr_s3[1] <= ray_s2[1] * ray_s2[3];
			bl_s3[0] <= base_s * ray_s2[0];
			bl_s3[1] <= base_s * ray_s2[2];

			a_s4  <= DOT_W'(sq_s3[0]) + DOT_W'(sq_s3[1]) + DOT_ONE;
			c_s4  <= DOT_W'(sq_s3[2]) + DOT_W'(sq_s3[3]) + DOT_ONE;
			m_s4  <= DOT_W'(lr_s3[0]) + DOT_W'(lr_s3[1]) + DOT_ONE;
			b0_s4 <= bl_s3[0];
			b1_s4 <= bl_s3[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= pair_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Products for the determinant and the two parameter numerators.
	smt_mul #(.WA(DOT_W), .WB(DOT_W)) u_mm (.clk, .arst_n, .en, .v_in(v_s4),
		.a(m_s4), .b(m_s4), .v_out(mm_v), .p(mm_p));
	smt_mul #(.WA(DOT_W), .WB(DOT_W)) u_ac (.clk, .arst_n, .en, .v_in(v_s4),
		.a(a_s4), .b(c_s4), .v_out(), .p(ac_p));
	smt_mul #(.WA(DOT_W), .WB(BL_W)) u_mb1 (.clk, .arst_n, .en, .v_in(v_s4),
		.a(m_s4), .b(b1_s4), .v_out(), .p(mb1_p));
	smt_mul #(.WA(DOT_W), .WB(BL_W)) u_cb0 (.clk, .arst_n, .en, .v_in(v_s4),
		.a(c_s4), .b(b0_s4), .v_out(), .p(cb0_p));
	smt_mul #(.WA(DOT_W), .WB(BL_W)) u_ab1 (.clk, .arst_n, .en, .v_in(v_s4),
		.a(a_s4), .b(b1_s4), .v_out(), .p(ab1_p));
	smt_mul #(.WA(DOT_W), .WB(BL_W)) u_mb0 (.clk, .arst_n, .en, .v_in(v_s4),
		.a(m_s4), .b(b0_s4), .v_out(), .p(mb0_p));

	// Carry the rays to the numerator products.
	assign ray_pack = {ray_s2[3], ray_s2[2], ray_s2[1], ray_s2[0]};
	smt_dly #(.W(4*RAY_W), .DEPTH(RAY_DLY)) u_ray_dly (.clk, .en, .d(ray_pack), .q(ray_dly));
	assign lx_d = $signed(ray_dly[0*RAY_W +: RAY_W]);
	assign ly_d = $signed(ray_dly[1*RAY_W +: RAY_W]);
	assign rx_d = $signed(ray_dly[2*RAY_W +: RAY_W]);
	assign ry_d = $signed(ray_dly[3*RAY_W +: RAY_W]);

	// Determinant and closest-approach numerators.
	always_ff @(posedge clk) begin
		if (en) begin
			det_s10 <= DET_W'(mm_p) - DET_W'(ac_p);
			nt_s10  <= NT_W'(mb1_p) - NT_W'(cb0_p);
			ns_s10  <= NT_W'(ab1_p) - NT_W'(mb0_p);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s10 <= 1'b0;
		else if (en)
			v_s10 <= mm_v;
	end

	// Products for the closest points.
	smt_mul #(.WA(NT_W), .WB(RAY_W)) u_ntlx (.clk, .arst_n, .en, .v_in(v_s10),
		.a(nt_s10), .b(lx_d), .v_out(ntlx_v), .p(ntlx_p));
	smt_mul #(.WA(NT_W), .WB(RAY_W)) u_nsrx (.clk, .arst_n, .en, .v_in(v_s10),
		.a(ns_s10), .b(rx_d), .v_out(), .p(nsrx_p));
	smt_mul #(.WA(NT_W), .WB(RAY_W)) u_ntly (.clk, .arst_n, .en, .v_in(v_s10),
		.a(nt_s10), .b(ly_d), .v_out(), .p(ntly_p));
	smt_mul #(.WA(NT_W), .WB(RAY_W)) u_nsry (.clk, .arst_n, .en, .v_in(v_s10),
		.a(ns_s10), .b(ry_d), .v_out(), .p(nsry_p));
	smt_mul #(.WA(DET_W), .WB(32)) u_detb (.clk, .arst_n, .en, .v_in(v_s10),
		.a(det_s10), .b(base_s), .v_out(), .p(detb_p));

	// Divisor, parallel flag and the z numerator travel beside the products.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s11  <= SUM_W'(nt_s10) + SUM_W'(ns_s10);
			den_s11  <= $signed({det_s10, 1'b0});
			zero_s11 <= det_s10 == '0;
		end
	end

	smt_dly #(.W(AUX_W), .DEPTH(AUX_DLY)) u_aux_dly (.clk, .en,
		.d({zero_s11, den_s11, sum_s11}), .q(aux_dly));
	assign sum_d  = $signed(aux_dly[SUM_W-1:0]);
	assign den_d  = $signed(aux_dly[SUM_W +: DEN_W]);
	assign zero_d = aux_dly[AUX_W-1];

	// Sum the x and y numerators over two stages.
	always_ff @(posedge clk) begin
		if (en) begin
			sxy_s16  <= ACC_W'(ntlx_p) + ACC_W'(nsrx_p);
			ny_s16   <= ACC_W'(ntly_p) + ACC_W'(nsry_p);
			detb_s16 <= detb_p;
			nx_s17   <= NUM_W'(sxy_s16 - ACC_W'(detb_s16));
			ny_s17   <= NUM_W'(ny_s16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s16 <= 1'b0;
			v_s17 <= 1'b0;
		end else if (en) begin
			v_s16 <= ntlx_v;
			v_s17 <= v_s16;
		end
	end

	assign num[0] = nx_s17;
	assign num[1] = ny_s17;
	assign num[2] = NUM_W'(sum_d) <<< RAY_FRAC;

	smt_div u_div (.clk, .arst_n, .en, .v_in(v_s17), .num, .den(den_d),
		.v_out(quo_v), .quo);

	smt_dly #(.W(1), .DEPTH(D_LAT)) u_zero_dly (.clk, .en, .d(zero_d), .q(zero_q));

	// Add the x offset, saturate, and zero the point for parallel rays.
	always_ff @(posedge clk) begin
		if (en) begin
			rays_parallel <= zero_q;
			if (zero_q) begin
				point_x <= '0;
				point_y <= '0;
				point_z <= '0;
			end else begin
				point_x <= sat32(43'(quo[0]) + 43'(off_q));
				point_y <= sat32(43'(quo[1]));
				point_z <= sat32(43'(quo[2]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			point_valid <= 1'b0;
		else if (en)
			point_valid <= quo_v;
	end
endmodule

[hw/rtl/smt_checker.sv]
// Port-level checks for the triangulation block, bound to its top level.
`include "assert_macros.svh"

module smt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pair_stall,
	input logic                          point_valid,
	input logic                          point_stall,
	input logic signed [31:0]            point_x,
	input logic signed [31:0]            point_y,
	input logic signed [31:0]            point_z,
	input logic                          rays_parallel
);
	// A parallel-ray result carries a zero point.
	`SMT_ASSERT_IMPLY(a_parallel_zero, clk, arst_n, point_valid && rays_parallel,
		point_x == 32'sd0 && point_y == 32'sd0 && point_z == 32'sd0)

	// The pair side is held back only by a waiting, stalled result.
	`SMT_ASSERT_IMPLY(a_stall_cause, clk, arst_n, pair_stall, point_valid && point_stall)

	// A stalled result stays and holds its payload.
	`SMT_ASSERT_NEXT(a_out_hold, clk, arst_n, point_valid && point_stall,
		point_valid && $stable(point_x) && $stable(point_y) && $stable(point_z) &&
		$stable(rays_parallel))
endmodule

bind stereo_midpoint_triangulation smt_checker u_smt_checker (.*);

[verif/smt_checker.sv]
// Checker for the triangulation block: watches the channels, predicts points and compares.
`timescale 1ns / 1ps

module smt_scoreboard
	import smt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pair_valid,
	input  logic                 pair_stall,
	input  logic [15:0]          left_px,
	input  logic [15:0]          left_py,
	input  logic [15:0]          right_px,
	input  logic [15:0]          right_py,
	input  logic                 point_valid,
	input  logic                 point_stall,
	input  logic signed [31:0]   point_x,
	input  logic signed [31:0]   point_y,
	input  logic signed [31:0]   point_z,
	input  logic                 rays_parallel,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output int                   fail_count,
	output int                   points_pending,
	output int                   points_seen,
	output int                   parallel_seen
);

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               par;
	} point_t;

	// Shadow copy of the register file
	logic signed [31:0] inv_fx, inv_fy, ctr_x, ctr_y, offset;
	logic [30:0]        baseline;

	point_t expected_points[$];

	// Pixel to Q.20 ray component: round half up, clamp to 24 bits
	function automatic longint ray_comp(logic [15:0] p, logic signed [31:0] k,
			logic signed [31:0] c);
		longint v;
		longint f;
		v = longint'({1'b0, p}) * longint'(k) + longint'(c) * 16;
		f = (v + 128) >>> 8;
		if (f > RAY_HI)
			f = RAY_HI;
		if (f < RAY_LO)
			f = RAY_LO;
		return f;
	endfunction

	// Nearest-integer quotient, ties away from zero, magnitude capped at 2^40
	function automatic longint div_nearest(logic signed [127:0] n, logic signed [127:0] d);
		logic [127:0] un, ud, q, r;
		logic [128:0] r2;
		logic         neg;
		neg = n[127] ^ d[127];
		un  = n[127] ? -n : n;
		ud  = d[127] ? -d : d;
		q   = un / ud;
		r   = un % ud;
		r2  = {r, 1'b0};
		if (r2 >= {1'b0, ud})
			q = q + 1;
		if (q > (128'd1 << 40))
			q = 128'd1 << 40;
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// Closest-approach midpoint of the left and right rays
	function automatic point_t predict_point(logic [15:0] lpx, logic [15:0] lpy,
			logic [15:0] rpx, logic [15:0] rpy);
		point_t p;
		longint lx, ly, rx, ry, one, aa, cc, mm, b0, b1, base;
		logic signed [127:0] wa, wc, wm, wb0, wb1, wlx, wly, wrx, wry, wbase;
		logic signed [127:0] det, nt, ns, d2, num;
		lx   = ray_comp(lpx, inv_fx, ctr_x);
		ly   = ray_comp(lpy, inv_fy, ctr_y);
		rx   = ray_comp(rpx, inv_fx, ctr_x);
		ry   = ray_comp(rpy, inv_fy, ctr_y);
		one  = 64'sd1 << 20;
		base = longint'({1'b0, baseline});
		aa   = lx * lx + ly * ly + one * one;
		cc   = rx * rx + ry * ry + one * one;
		mm   = lx * rx + ly * ry + one * one;
		b0   = base * lx;
		b1   = base * rx;
		wa = aa; wc = cc; wm = mm; wb0 = b0; wb1 = b1; wbase = base;
		wlx = lx; wly = ly; wrx = rx; wry = ry;
		det = wm * wm - wa * wc;
		if (det == 0) begin
			p.x = 0; p.y = 0; p.z = 0; p.par = 1'b1;
			return p;
		end
		nt  = wm * wb1 - wc * wb0;
		ns  = wa * wb1 - wm * wb0;
		d2  = det + det;
		num = nt * wlx + ns * wrx - det * wbase;
		p.x = clamp32(div_nearest(num, d2) + longint'(offset));
		num = nt * wly + ns * wry;
		p.y = clamp32(div_nearest(num, d2));
		num = (nt + ns) * (128'sd1 <<< 20);
		p.z = clamp32(div_nearest(num, d2));
		p.par = 1'b0;
		return p;
	endfunction

	// Track registers, queue predictions, compare delivered points
	always @(posedge clk or negedge arst_n) begin
		point_t e;
		if (!arst_n) begin
			inv_fx <= 0; inv_fy <= 0; ctr_x <= 0; ctr_y <= 0;
			baseline <= BASE_RST; offset <= OFF_RST;
			expected_points.delete();
			fail_count <= 0; points_seen <= 0; parallel_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					IDX_INV_FX:   inv_fx   <= cfg_data;
					IDX_INV_FY:   inv_fy   <= cfg_data;
					IDX_CENTRE_X: ctr_x    <= cfg_data;
					IDX_CENTRE_Y: ctr_y    <= cfg_data;
					IDX_BASELINE: baseline <= cfg_data[30:0];
					IDX_OFFSET:   offset   <= cfg_data;
					default: ;
				endcase
			end
			if (pair_valid && !pair_stall)
				expected_points = {expected_points,
					predict_point(left_px, left_py, right_px, right_py)};
			if (point_valid && !point_stall) begin
				points_seen <= points_seen + 1;
				if (rays_parallel)
					parallel_seen <= parallel_seen + 1;
				if (expected_points.size() == 0) begin
					if (fail_count < 10)
						$display("ERROR: point delivered with no pair outstanding");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_points.pop_front();
					if (e.x !== point_x || e.y !== point_y || e.z !== point_z ||
							e.par !== rays_parallel) begin
						if (fail_count < 10)
							$display("ERROR: point exp (%0d %0d %0d par=%0b) got (%0d %0d %0d par=%0b)",
								e.x, e.y, e.z, e.par, point_x, point_y, point_z, rays_parallel);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

	assign points_pending = expected_points.size();

endmodule

[verif/tb_stereo_midpoint_triangulation.sv]
// Testbench top: drives pairs and register writes into the triangulation block and reports.
`timescale 1ns / 1ps

module tb_stereo_midpoint_triangulation;
	import smt_pkg::*;

	localparam int   LIMIT      = 400000;
	localparam int   DRAIN_WAIT = 80;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 pair_valid;
	logic                 pair_stall;
	logic [15:0]          left_px, left_py, right_px, right_py;
	logic                 point_valid;
	logic                 point_stall;
	logic signed [31:0]   point_x, point_y, point_z;
	logic                 rays_parallel;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	int  fail_count, points_pending, points_seen, parallel_seen;
	int  cycle_count;
	int  pairs_sent;
	bit  quiet;
	bit  hold_req;

	stereo_midpoint_triangulation dut (.*);

	smt_scoreboard u_checker (.*);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Output side: random stall bursts, plus one long hold-off on request
	initial begin
		point_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				point_stall <= 1'b1;
				repeat (300) @(posedge clk);
				point_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!quiet && arst_n && $urandom_range(0, 9) == 0) begin
				point_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				point_stall <= 1'b0;
			end
		end
	end

	// Offer one pair and hold it until taken; maybe idle afterwards
	task automatic send_pair(logic [15:0] lpx, logic [15:0] lpy, logic [15:0] rpx,
			logic [15:0] rpy);
		pair_valid <= 1'b1;
		left_px <= lpx; left_py <= lpy; right_px <= rpx; right_py <= rpy;
		@(posedge clk);
		while (pair_stall)
			@(posedge clk);
		pairs_sent++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			pair_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Drop valid and let the pipeline empty
	task automatic drain();
		pair_valid <= 1'b0;
		@(posedge clk);
		while (points_pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
			logic [31:0] cy, logic [31:0] bl, logic [31:0] off);
		write_reg(IDX_INV_FX, fx);
		write_reg(IDX_INV_FY, fy);
		write_reg(IDX_CENTRE_X, cx);
		write_reg(IDX_CENTRE_Y, cy);
		write_reg(IDX_BASELINE, bl);
		write_reg(IDX_OFFSET, off);
	endtask

	// Random configuration: camera-like most of the time, raw bits otherwise
	task automatic random_config(int kind);
		int f;
		f = $urandom_range(200, 2000);
		if (kind == 0)
			write_all((32'd1 << 24) / f, (32'd1 << 24) / f,
				-$urandom_range(0, 32'd1 << 24), -$urandom_range(0, 32'd1 << 24),
				$urandom_range(0, 32'd1 << 18), $urandom());
		else
			write_all($urandom(), $urandom(), $urandom(), $urandom(),
				$urandom_range(0, 1) ? $urandom() : 32'h7fffffff, $urandom());
	endtask

	// Random pair: mostly a plausible stereo match, some noise, some identical
	task automatic random_pair();
		logic [15:0] lpx, lpy;
		int sel;
		lpx = 16'($urandom());
		lpy = 16'($urandom());
		sel = $urandom_range(0, 19);
		if (sel < 14)
			send_pair(lpx, lpy, lpx - 16'($urandom_range(0, 2000)),
				lpy + 16'($urandom_range(0, 8)) - 16'd4);
		else if (sel < 17)
			send_pair(lpx, lpy, 16'($urandom()), 16'($urandom()));
		else
			send_pair(lpx, lpy, lpx, lpy);
	endtask

	initial begin
		clk = 1'b0; arst_n = 1'b0;
		pair_valid = 1'b0; left_px = '0; left_py = '0; right_px = '0; right_py = '0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		cycle_count = 0; pairs_sent = 0; quiet = 1'b0; hold_req = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: every ray is the optical axis, so all parallel
		send_pair(16'd0, 16'd0, 16'hffff, 16'hffff);
		send_pair(16'd5120, 16'd3840, 16'd4800, 16'd3840);
		drain();

		// Typical camera: extremes of the pixel fields, identical pixels, disparity
		write_all(32'd33554, 32'd33554, -32'sd10737418, -32'sd8053064, 32'd7864, 32'd7864);
		send_pair(16'd0, 16'd0, 16'd0, 16'd0);
		send_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_pair(16'hffff, 16'hffff, 16'd0, 16'd0);
		send_pair(16'd0, 16'd0, 16'hffff, 16'hffff);
		send_pair(16'd5120, 16'd3840, 16'd4800, 16'd3840);
		send_pair(16'd5120, 16'd3840, 16'd5121, 16'd3840);
		send_pair(16'd5120, 16'd3840, 16'd5120, 16'd3841);
		send_pair(16'h8000, 16'h0001, 16'h7fff, 16'h0001);
		send_pair(16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
		drain();

		// Extreme registers: saturated rays and saturated coordinates
		write_all(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff);
		write_reg(IDX_SPARE, 32'hdeadbeef);
		send_pair(16'd0, 16'd0, 16'hffff, 16'hffff);
		send_pair(16'hffff, 16'd0, 16'd0, 16'hffff);
		send_pair(16'd1, 16'd2, 16'd3, 16'd4);
		drain();
		write_all(32'd33554, 32'd33554, -32'sd10737418, -32'sd8053064, 32'd0, 32'h80000000);
		send_pair(16'd5120, 16'd3840, 16'd4800, 16'd3840);
		send_pair(16'd100, 16'd200, 16'd90, 16'd200);
		drain();

		// Random phases; the second one starts with a long output hold-off
		for (int ph = 0; ph < 7; ph++) begin
			random_config(ph % 3 == 2);
			if (ph == 1)
				hold_req = 1'b1;
			if (ph == 6)
				quiet = 1'b1;
			for (int i = 0; i < 140; i++)
				random_pair();
			drain();
		end

		$display("Sent %0d keypoint pairs over typical, extreme and random register settings;",
			pairs_sent);
		$display("received %0d points, %0d of them flagged as parallel rays.",
			points_seen, parallel_seen);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/smt_pkg.sv
hw/rtl/smt_dly.sv
hw/rtl/smt_mul.sv
hw/rtl/smt_div.sv
hw/rtl/stereo_midpoint_triangulation.sv
hw/rtl/smt_checker.sv
verif/smt_checker.sv
verif/tb_stereo_midpoint_triangulation.sv
